/* rtl/sbsc_pkg.sv */
// Shared types, constants and the commutation table of the six-step commutator.
package sbsc_pkg;

    localparam int TIMER_BITS_DEF = 8;

    localparam logic [7:0] START_DUTY_RST    = 8'd10;
    localparam logic [7:0] DUTY_STEP_RST     = 8'd5;
    localparam logic [7:0] LOCK_COUNT_RST    = 8'd200;
    localparam logic [8:0] TIMEOUT_TICKS_RST = 9'd256;
    localparam logic [7:0] WORK_DUTY_RST     = 8'd100;
    localparam logic [7:0] DUTY_MAX          = 8'd255;
    localparam logic [2:0] LAST_STEP         = 3'd5;

    typedef enum logic [1:0] {
        REG_START_DUTY    = 2'd0,
        REG_DUTY_STEP     = 2'd1,
        REG_LOCK_COUNT    = 2'd2,
        REG_TIMEOUT_TICKS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic run_enable;
        logic dir_switch;
        logic comp_event;
        logic comp_level;
        logic timer_tick;
        logic speed_press;
        logic speed_up;
    } sbsc_in_t;

    typedef struct packed {
        logic [2:0] high_enables;
        logic [2:0] low_enables;
        logic [1:0] sense_phase;
        logic [7:0] duty;
        logic       lock_lamp;
        logic [2:0] step_now;
    } sbsc_out_t;

    // Bridge state touched by a commutation.
    typedef struct packed {
        logic [2:0] step;
        logic [2:0] high;
        logic [2:0] low;
        logic [1:0] sense;
    } sbsc_sw_t;

    typedef struct packed {
        logic       is_low;
        logic [2:0] set_mask;
        logic [2:0] clr_mask;
        logic [1:0] sense;
    } step_act_t;

    // Switch action per direction and step.
    function automatic step_act_t step_act(input logic dir, input logic [2:0] s);
        step_act_t a;
        case ({dir, s})
            4'h0:    a = '{1'b0, 3'd4, 3'd1, 2'd0};
            4'h1:    a = '{1'b1, 3'd1, 3'd2, 2'd1};
            4'h2:    a = '{1'b0, 3'd2, 3'd4, 2'd2};
            4'h3:    a = '{1'b1, 3'd4, 3'd1, 2'd0};
            4'h4:    a = '{1'b0, 3'd1, 3'd2, 2'd1};
            4'h5:    a = '{1'b1, 3'd2, 3'd4, 2'd2};
            4'h8:    a = '{1'b0, 3'd1, 3'd4, 2'd2};
            4'h9:    a = '{1'b1, 3'd4, 3'd2, 2'd1};
            4'hA:    a = '{1'b0, 3'd2, 3'd1, 2'd0};
            4'hB:    a = '{1'b1, 3'd1, 3'd4, 2'd2};
            4'hC:    a = '{1'b0, 3'd4, 3'd2, 2'd1};
            4'hD:    a = '{1'b1, 3'd2, 3'd1, 2'd0};
            default: a = '0;
        endcase
        return a;
    endfunction

    // Apply one commutation: switch update, sensed phase, next step.
    function automatic sbsc_sw_t sw_advance(input sbsc_sw_t sw, input logic dir);
        sbsc_sw_t  r;
        logic [2:0] s;
        step_act_t a;
        r = sw;
        s = (sw.step > LAST_STEP) ? 3'd0 : sw.step;
        a = step_act(dir, s);
        if (a.is_low)
        begin
            r.low = (sw.low | a.set_mask) & ~a.clr_mask;
        end
        else
        begin
            r.high = (sw.high | a.set_mask) & ~a.clr_mask;
        end
        r.sense = a.sense;
        r.step  = (s == LAST_STEP) ? 3'd0 : s + 3'd1;
        return r;
    endfunction

endpackage

/* rtl/sbsc_if.sv */
// Valid/ready stream interfaces for commutator input and result beats.
interface sbsc_in_if
    import sbsc_pkg::*;
;
    logic     valid;
    logic     ready;
    sbsc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbsc_out_if
    import sbsc_pkg::*;
;
    logic      valid;
    logic      ready;
    sbsc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sensorless_bldc_six_step_commutator_unit.sv */
// Six-step sensorless BLDC commutator: input register, update logic, result register.
//
//  channel   dir  handshake          payload
//  item_in   in   valid/ready        run, dir, comparator event/level, tick, press
//  res_out   out  valid/ready        switch enables, sense phase, duty, lamp, step
//  apb       in   psel/penable/...   start_duty, duty_step, lock_count, timeout_ticks
//
//  One beat per cycle sustained while res_out is ready; an accepted beat's result is
//  written from the input register into the result register and held there until taken.
//  The update of all motor state is one combinational pass from the input register
//  and the state registers into the state and result registers.
//  Reset (rst_n low) puts configuration and state registers at power-on values, no beat held.
//  A stalled result holds; the input register still takes a beat whenever the
//  result register is empty or drains in the same cycle.
module sensorless_bldc_six_step_commutator_unit
    import sbsc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    sbsc_in_if.sink     item_in,
    sbsc_out_if.source  res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Tick counter holds up to 2^TIMER_BITS; compares run at the wider of it and 9 bits.
    localparam int TW = TIMER_BITS + 1;
    localparam int CW = (TW > 9) ? TW : 9;
    localparam logic [CW-1:0] TMAX = CW'(1) << TIMER_BITS;

    // ---------------- configuration registers ----------------
    logic [7:0] start_duty_reg;
    logic [7:0] duty_step_reg;
    logic [7:0] lock_count_reg;
    logic [8:0] timeout_reg;
    logic       cfg_wr;
    cfg_reg_t   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_duty_reg <= START_DUTY_RST;
            duty_step_reg  <= DUTY_STEP_RST;
            lock_count_reg <= LOCK_COUNT_RST;
            timeout_reg    <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_START_DUTY:    start_duty_reg <= pwdata[7:0];
                REG_DUTY_STEP:     duty_step_reg  <= pwdata[7:0];
                REG_LOCK_COUNT:    lock_count_reg <= pwdata[7:0];
                REG_TIMEOUT_TICKS: timeout_reg    <= pwdata[8:0];
                default:           start_duty_reg <= start_duty_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_START_DUTY:    prdata = {24'd0, start_duty_reg};
            REG_DUTY_STEP:     prdata = {24'd0, duty_step_reg};
            REG_LOCK_COUNT:    prdata = {24'd0, lock_count_reg};
            REG_TIMEOUT_TICKS: prdata = {23'd0, timeout_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic     in_valid_reg;
    sbsc_in_t in_data_reg;
    logic     out_valid_reg;
    sbsc_out_t out_data_reg;
    logic     fire;

    // Fire the update when a beat is held and the result slot is free or draining.
    assign fire          = in_valid_reg && (!out_valid_reg || res_out.ready);
    assign item_in.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            in_data_reg <= item_in.data;
        end
    end

    // ---------------- motor state ----------------
    sbsc_sw_t      sw_reg,    sw_next;
    logic [7:0]    cross_reg, cross_next;
    logic [TW-1:0] tick_reg,  tick_next;
    logic [7:0]    wduty_reg, wduty_next;
    logic [7:0]    aduty_reg, aduty_next;
    logic          dir_reg,   dir_next;
    logic          lamp_reg,  lamp_next;
    sbsc_out_t     out_data_next;

    logic [CW-1:0] tmo_ext;
    logic [CW-1:0] limit;
    logic [8:0]    duty_sum;
    logic [7:0]    duty_gap;

    // Timeout of zero or beyond the counter range means the full counter range.
    assign tmo_ext = CW'(timeout_reg);
    assign limit   = (tmo_ext == '0 || tmo_ext > TMAX) ? TMAX : tmo_ext;

    assign duty_sum = {1'b0, wduty_reg} + {1'b0, duty_step_reg};
    assign duty_gap = wduty_reg - start_duty_reg;

    always_comb
    begin
        sw_next    = sw_reg;
        cross_next = cross_reg;
        tick_next  = tick_reg;
        wduty_next = wduty_reg;
        aduty_next = aduty_reg;
        dir_next   = dir_reg;
        lamp_next  = lamp_reg;

        if (in_data_reg.run_enable)
        begin
            // Comparator event: bump the count, commutate at lock on matching parity.
            if (in_data_reg.comp_event)
            begin
                cross_next = (cross_reg < lock_count_reg) ? cross_reg + 8'd1
                                                          : lock_count_reg;
                if (cross_next == lock_count_reg
                    && in_data_reg.comp_level == sw_reg.step[0])
                begin
                    sw_next   = sw_advance(sw_reg, dir_reg);
                    tick_next = '0;
                end
            end
            // Timer tick: force a commutation at timeout, drop back to start duty.
            if (in_data_reg.timer_tick)
            begin
                tick_next = tick_next + TW'(1);
                if (CW'(tick_next) >= limit)
                begin
                    cross_next = '0;
                    aduty_next = start_duty_reg;
                    sw_next    = sw_advance(sw_next, dir_reg);
                    tick_next  = '0;
                end
            end
            // Speed button: saturate up at full scale, down at start duty.
            if (in_data_reg.speed_press)
            begin
                if (in_data_reg.speed_up)
                begin
                    wduty_next = duty_sum[8] ? DUTY_MAX : duty_sum[7:0];
                end
                else if (wduty_reg > start_duty_reg)
                begin
                    wduty_next = (duty_gap > duty_step_reg) ? wduty_reg - duty_step_reg
                                                            : start_duty_reg;
                end
            end
            if (cross_next == lock_count_reg)
            begin
                aduty_next = wduty_next;
                lamp_next  = 1'b1;
            end
        end
        else
        begin
            // Stopped: latch direction, bridge off, lamp off.
            dir_next     = in_data_reg.dir_switch;
            lamp_next    = 1'b0;
            sw_next.high = '0;
            sw_next.low  = '0;
        end

        out_data_next.high_enables = sw_next.high;
        out_data_next.low_enables  = sw_next.low;
        out_data_next.sense_phase  = sw_next.sense;
        out_data_next.duty         = in_data_reg.run_enable ? aduty_next : 8'd0;
        out_data_next.lock_lamp    = lamp_next;
        out_data_next.step_now     = sw_next.step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= '0;
            cross_reg <= '0;
            tick_reg  <= '0;
            wduty_reg <= WORK_DUTY_RST;
            aduty_reg <= '0;
            dir_reg   <= 1'b1;
            lamp_reg  <= 1'b0;
        end
        else if (fire)
        begin
            sw_reg    <= sw_next;
            cross_reg <= cross_next;
            tick_reg  <= tick_next;
            wduty_reg <= wduty_next;
            aduty_reg <= aduty_next;
            dir_reg   <= dir_next;
            lamp_reg  <= lamp_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_data_reg;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> (in_valid_reg && out_valid_reg && !res_out.ready))
        else $error("input stalled while the pipeline can advance");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        sw_reg.step <= LAST_STEP)
        else $error("step index left the six-step range");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(tick_reg) < TMAX)
        else $error("tick counter reached the timeout without commutating");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.ready && !fire) |=> !res_out.valid)
        else $error("result beat repeated after being taken");

    a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_data_reg.run_enable) |=>
            (res_out.data.high_enables == 3'd0 && res_out.data.low_enables == 3'd0
             && res_out.data.duty == 8'd0 && !res_out.data.lock_lamp))
        else $error("bridge not off while stopped");

endmodule

/* tb/tb_sensorless_bldc_six_step_commutator_unit.sv */
// Testbench: directed table and random traffic for the six-step commutator, checked beat by beat.
module tb_sensorless_bldc_six_step_commutator_unit;
    import sbsc_pkg::*;

    // Directed row: optional register write before the beat, optional typed result.
    typedef struct {
        bit         cfg_en;
        cfg_reg_t   cfg_reg;
        logic [8:0] cfg_val;
        sbsc_in_t   beat;
        bit         exp_en;
        sbsc_out_t  exp;
    } drive_row_t;

    // Random phase: register setting, idle mode and beat count.
    typedef struct {
        logic [7:0] start_duty;
        logic [7:0] duty_step;
        logic [7:0] lock_count;
        logic [8:0] timeout_ticks;
        int         mode;
        int         beats;
    } run_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sbsc_in_if  item_if ();
    sbsc_out_if res_if ();

    sensorless_bldc_six_step_commutator_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_if),
        .res_out (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the programmed registers.
    logic [7:0] c_start;
    logic [7:0] c_dstep;
    logic [7:0] c_lock;
    logic [8:0] c_tmo;

    // Mirror of the motor state.
    logic [2:0] p_step;
    logic [2:0] p_high;
    logic [2:0] p_low;
    logic [1:0] p_sense;
    logic [7:0] p_cross;
    logic [8:0] p_ticks;
    logic [7:0] p_work;
    logic [7:0] p_applied;
    logic       p_dir;
    logic       p_lamp;

    sbsc_out_t  pending_drive[$];
    int         fault_count = 0;
    int         results_seen = 0;
    int         send_gap_pct = 0;
    int         recv_gap_pct = 0;
    int         hold_left = 0;
    bit         held_once = 1'b0;

    // Advance one step of the bridge. Steps repeat every three in switch pattern;
    // odd steps touch the low side, even steps the high side. Reverse direction
    // mirrors U and W.
    function automatic void commutate();
        logic [2:0] s;
        logic [2:0] set_m;
        logic [2:0] clr_m;
        int         k;
        s = (p_step > 3'd5) ? 3'd0 : p_step;
        k = s % 3;
        case (k)
            0:
            begin
                set_m = p_dir ? 3'b001 : 3'b100;
                clr_m = p_dir ? 3'b100 : 3'b001;
            end
            1:
            begin
                set_m = p_dir ? 3'b100 : 3'b001;
                clr_m = 3'b010;
            end
            default:
            begin
                set_m = 3'b010;
                clr_m = p_dir ? 3'b001 : 3'b100;
            end
        endcase
        if (s[0])
            p_low = (p_low | set_m) & ~clr_m;
        else
            p_high = (p_high | set_m) & ~clr_m;
        p_sense = p_dir ? 2'(2 - k) : 2'(k);
        p_step  = (s == 3'd5) ? 3'd0 : s + 3'd1;
        p_ticks = '0;
    endfunction

    // Work out the result of one accepted beat and update the mirrored state.
    // Order: comparator event, timer tick, speed press, lock check.
    function automatic sbsc_out_t commutator_next(input sbsc_in_t b);
        sbsc_out_t  r;
        logic [8:0] limit;
        logic [8:0] sum;
        limit = (c_tmo == 9'd0 || c_tmo > 9'd256) ? 9'd256 : c_tmo;
        if (b.run_enable)
        begin
            if (b.comp_event)
            begin
                // Saturate at the lock count; a lowered lock count clamps here.
                if (p_cross < c_lock)
                    p_cross = p_cross + 8'd1;
                else
                    p_cross = c_lock;
                if (p_cross == c_lock && b.comp_level == p_step[0])
                    commutate();
            end
            if (b.timer_tick)
            begin
                p_ticks = p_ticks + 9'd1;
                if (p_ticks >= limit)
                begin
                    // Forced step: drop the lock and fall back to the start duty.
                    p_cross   = '0;
                    p_applied = c_start;
                    commutate();
                end
            end
            if (b.speed_press)
            begin
                if (b.speed_up)
                begin
                    sum    = {1'b0, p_work} + {1'b0, c_dstep};
                    p_work = (sum > 9'd255) ? 8'd255 : sum[7:0];
                end
                else if (p_work > c_start)
                begin
                    if (p_work - c_start > c_dstep)
                        p_work = p_work - c_dstep;
                    else
                        p_work = c_start;
                end
            end
            if (p_cross == c_lock)
            begin
                p_applied = p_work;
                p_lamp    = 1'b1;
            end
        end
        else
        begin
            // Stopped: latch direction, bridge off, lamp off, rest kept.
            p_dir  = b.dir_switch;
            p_lamp = 1'b0;
            p_high = '0;
            p_low  = '0;
        end
        r.high_enables = p_high;
        r.low_enables  = p_low;
        r.sense_phase  = p_sense;
        r.duty         = b.run_enable ? p_applied : 8'd0;
        r.lock_lamp    = p_lamp;
        r.step_now     = p_step;
        return r;
    endfunction

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // Result side: check every accepted beat, then pick the next ready.
    // Once, hold ready low for a long stretch so the block fills and stalls its input.
    always @(posedge clk)
    begin
        sbsc_out_t want;
        sbsc_out_t got;
        if (res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            results_seen++;
            if (pending_drive.size() == 0)
            begin
                fault_count++;
                $display("%0t: result beat with nothing pending, expected none, got %h",
                         $time, got);
            end
            else
            begin
                want = pending_drive.pop_front();
                compare_field("high_enables", want.high_enables, got.high_enables);
                compare_field("low_enables", want.low_enables, got.low_enables);
                compare_field("sense_phase", want.sense_phase, got.sense_phase);
                compare_field("duty", want.duty, got.duty);
                compare_field("lock_lamp", want.lock_lamp, got.lock_lamp);
                compare_field("step_now", want.step_now, got.step_now);
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else if (results_seen == 150 && !held_once)
        begin
            held_once = 1'b1;
            hold_left = 60;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Offer one beat, with random gaps ahead of it, and hold it until accepted.
    // Record the expected result at the accepting edge.
    task automatic send_beat(input sbsc_in_t b, input bit exp_en, input sbsc_out_t exp_typed);
        sbsc_out_t pred;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= b;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        pred = commutator_next(b);
        pending_drive.push_back(exp_en ? exp_typed : pred);
    endtask

    // Drop valid and let every pending result come out.
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phases; the register takes the value at the access edge.
    task automatic reg_write(input cfg_reg_t idx, input logic [8:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_DUTY:    c_start = val[7:0];
            REG_DUTY_STEP:     c_dstep = val[7:0];
            REG_LOCK_COUNT:    c_lock  = val[7:0];
            REG_TIMEOUT_TICKS: c_tmo   = val;
            default:           ;
        endcase
    endtask

    // Generous fixed bound on the whole run.
    initial
    begin
        #1600000;
        $display("sensorless_bldc_six_step_commutator_unit verification failed");
        $finish;
    end

    initial
    begin
        drive_row_t drive_rows[$];
        run_phase_t phases[$];
        sbsc_in_t   b;
        sbsc_out_t  none_out;
        int         pick;

        none_out = '0;

        // Hold every input at a known value from the start.
        item_if.valid = 1'b0;
        item_if.data  = '0;
        res_if.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // Power-on state of the mirrored registers and motor.
        c_start   = START_DUTY_RST;
        c_dstep   = DUTY_STEP_RST;
        c_lock    = LOCK_COUNT_RST;
        c_tmo     = TIMEOUT_TICKS_RST;
        p_step    = '0;
        p_high    = '0;
        p_low     = '0;
        p_sense   = '0;
        p_cross   = '0;
        p_ticks   = '0;
        p_work    = WORK_DUTY_RST;
        p_applied = '0;
        p_dir     = 1'b1;
        p_lamp    = 1'b0;

        // Beat bits, MSB first: run, dir, event, level, tick, press, up.
        // Right after reset nothing is locked and nothing has been applied: all zero.
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b0000000, 1'b1, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1000000, 1'b1, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1000011, 1'b1, none_out});
        // Lock after one event; walk a full turn, one wrong-parity event included.
        drive_rows.push_back('{1'b1, REG_LOCK_COUNT, 9'd1, 7'b1010000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1010000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1011000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1010000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1011000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1010000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1011000, 1'b0, none_out});
        // Two ticks reach the timeout: forced step, lock lost, start duty applied.
        drive_rows.push_back('{1'b1, REG_TIMEOUT_TICKS, 9'd2, 7'b1000100, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1000100, 1'b0, none_out});
        // Largest step: press up saturates working duty.
        drive_rows.push_back('{1'b1, REG_DUTY_STEP, 9'd255, 7'b1000011, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1010011, 1'b0, none_out});
        // Press down at the start duty keeps duty; with start zero it falls to zero.
        drive_rows.push_back('{1'b1, REG_START_DUTY, 9'd255, 7'b1000010, 1'b0, none_out});
        drive_rows.push_back('{1'b1, REG_START_DUTY, 9'd0, 7'b1000010, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1000010, 1'b0, none_out});
        // Lock count zero below the current count: next event clamps and locks.
        drive_rows.push_back('{1'b1, REG_LOCK_COUNT, 9'd0, 7'b1011000, 1'b0, none_out});
        // Timeout zero means the full counter range.
        drive_rows.push_back('{1'b1, REG_TIMEOUT_TICKS, 9'd0, 7'b1000100, 1'b0, none_out});
        // Stop with reverse direction latched, then run reverse.
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b0100000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1000000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1110000, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1111000, 1'b0, none_out});
        // Timeout above the counter range, every bit set.
        drive_rows.push_back('{1'b1, REG_TIMEOUT_TICKS, 9'd511, 7'b1111111, 1'b0, none_out});
        drive_rows.push_back('{1'b0, REG_START_DUTY, 9'd0, 7'b1010000, 1'b0, none_out});

        // Register settings for the random part; modes: 0 sender 29/receiver 45,
        // 1 the other way round, 2 no idling.
        phases.push_back('{8'd10, 8'd5, 8'd3, 9'd20, 0, 180});
        phases.push_back('{8'd0, 8'd1, 8'd1, 9'd1, 0, 180});
        phases.push_back('{8'd255, 8'd255, 8'd255, 9'd256, 1, 170});
        phases.push_back('{8'd50, 8'd17, 8'd8, 9'd300, 1, 180});
        phases.push_back('{8'd30, 8'd40, 8'd0, 9'd0, 1, 180});
        phases.push_back('{8'd100, 8'd3, 8'd5, 9'd40, 2, 180});
        phases.push_back('{8'd10, 8'd5, 8'd200, 9'd256, 2, 180});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        send_gap_pct = 29;
        recv_gap_pct = 45;
        foreach (drive_rows[i])
        begin
            if (drive_rows[i].cfg_en)
            begin
                wait_drained();
                reg_write(drive_rows[i].cfg_reg, drive_rows[i].cfg_val);
            end
            send_beat(drive_rows[i].beat, drive_rows[i].exp_en, drive_rows[i].exp);
        end

        // Random phases: mostly running beats whose comparator level tends to
        // match the step parity so lock and closed-loop stepping are reached;
        // the rest are stops and fully random noise.
        foreach (phases[p])
        begin
            wait_drained();
            reg_write(REG_START_DUTY, {1'b0, phases[p].start_duty});
            reg_write(REG_DUTY_STEP, {1'b0, phases[p].duty_step});
            reg_write(REG_LOCK_COUNT, {1'b0, phases[p].lock_count});
            reg_write(REG_TIMEOUT_TICKS, phases[p].timeout_ticks);
            case (phases[p].mode)
                0:
                begin
                    send_gap_pct = 29;
                    recv_gap_pct = 45;
                end
                1:
                begin
                    send_gap_pct = 45;
                    recv_gap_pct = 29;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            repeat (phases[p].beats)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    b = sbsc_in_t'(7'($urandom_range(0, 127)));
                end
                else
                begin
                    b.run_enable  = (pick >= 13);
                    b.dir_switch  = 1'($urandom_range(0, 1));
                    b.comp_event  = ($urandom_range(0, 99) < 55);
                    b.comp_level  = ($urandom_range(0, 99) < 75) ? p_step[0] : ~p_step[0];
                    b.timer_tick  = ($urandom_range(0, 99) < 30);
                    b.speed_press = ($urandom_range(0, 99) < 15);
                    b.speed_up    = 1'($urandom_range(0, 1));
                end
                send_beat(b, 1'b0, none_out);
            end
        end

        wait_drained();
        if (fault_count == 0)
            $display("sensorless_bldc_six_step_commutator_unit verification clean");
        else
            $display("sensorless_bldc_six_step_commutator_unit verification failed");
        $finish;
    end

endmodule
